[rtl/core/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the table-driven Huffman bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int MODE_W   = 2;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;

  // Longest code accepted on load; longer lengths saturate to the code word width.
  localparam int MAX_CODE_LEN = 32;
  localparam int CAP_LEN      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // Pending bits never reach a whole byte.
  localparam int PEND_W  = BYTE_W - 1;
  localparam int PCNT_W  = 3;
  // Work window: pending bits followed by one full code word, plus spare bit.
  localparam int WORK_W  = PEND_W + CODE_W + 1;
  localparam int TOTAL_W = 6;

  // Decoupling queue between classification and packing.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  // One unit of packing work handed from front to back.
  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hcbp_op_t;

endpackage

[rtl/core/hcbp_in_if.sv]
// ----------------------------------------------------------------------------
// hcbp_in_if
// Input channel: load, encode and flush items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcbp_in_if;
  logic                        valid;
  logic                        ready;
  logic [hcbp_pkg::MODE_W-1:0] mode;
  logic [hcbp_pkg::SYM_W-1:0]  symbol;
  logic [hcbp_pkg::CODE_W-1:0] code_word;
  logic [hcbp_pkg::LEN_W-1:0]  code_length;

  modport source (output valid, mode, symbol, code_word, code_length, input ready);
  modport sink   (input valid, mode, symbol, code_word, code_length, output ready);
endinterface

[rtl/core/hcbp_out_if.sv]
// ----------------------------------------------------------------------------
// hcbp_out_if
// Output channel: packed bytes with a last marker, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcbp_out_if;
  logic                        valid;
  logic                        ready;
  logic [hcbp_pkg::BYTE_W-1:0] out_byte;
  logic                        last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

[rtl/core/hcbp_front.sv]
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts words, keeps the code table and turns encode/flush words into ops.
// ----------------------------------------------------------------------------
module hcbp_front #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  hcbp_in_if.sink             in_chan,
  output logic                push_valid,
  input  logic                push_ready,
  output hcbp_pkg::hcbp_op_t  push_op
);
  import hcbp_pkg::*;

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [CODE_W-1:0]       code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_r;

  logic                    s1_valid_r;
  logic                    s1_flush_r;
  logic [CODE_W-1:0]       rd_code_r;
  logic [LEN_W-1:0]        rd_len_r;
  logic                    rd_vld_r;

  mode_t                   mode;
  logic                    accept;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;
  logic [LEN_W-1:0]        sat_len;
  logic [CODE_W-1:0]       masked_code;
  logic                    do_load;
  logic                    do_read;
  logic                    s1_load;
  logic [LEN_W-1:0]        eff_len;
  logic                    s1_useful;
  logic                    s1_adv;

  assign mode     = mode_t'(in_chan.mode);
  assign in_range = {1'b0, in_chan.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign idx      = in_chan.symbol[IDX_W-1:0];
  assign accept   = in_chan.valid && in_chan.ready;

  assign sat_len     = (in_chan.code_length > LEN_W'(CAP_LEN)) ? LEN_W'(CAP_LEN)
                                                               : in_chan.code_length;
  // keep only the low sat_len bits; a full-width length keeps all of them
  assign masked_code = in_chan.code_word & ~({CODE_W{1'b1}} << sat_len);

  assign do_load = accept && (mode == MODE_LOAD) && in_range;
  assign do_read = accept && (mode == MODE_ENCODE) && in_range;
  assign s1_load = do_read || (accept && (mode == MODE_FLUSH));

  // an entry never loaded reads as length zero
  assign eff_len   = rd_vld_r ? rd_len_r : '0;
  assign s1_useful = s1_flush_r || (eff_len != '0);
  assign s1_adv    = s1_valid_r && (push_ready || !s1_useful);

  assign in_chan.ready = !s1_valid_r || s1_adv;

  assign push_valid       = s1_valid_r && s1_useful;
  assign push_op.is_flush = s1_flush_r;
  assign push_op.code     = rd_code_r;
  assign push_op.len      = s1_flush_r ? '0 : eff_len;

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_mem[idx] <= masked_code;
      len_mem[idx]  <= sat_len;
    end
    if (do_read) begin
      rd_code_r <= code_mem[idx];
      rd_len_r  <= len_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (do_load) begin
        vld_r[idx] <= 1'b1;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
        s1_flush_r <= (mode == MODE_FLUSH);
        rd_vld_r   <= do_read && vld_r[idx];
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/hcbp_queue.sv]
// ----------------------------------------------------------------------------
// hcbp_queue
// Short FIFO of packing ops between the front and the back.
// ----------------------------------------------------------------------------
module hcbp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  hcbp_pkg::hcbp_op_t push_op,
  output logic               pop_valid,
  input  logic               pop,
  output hcbp_pkg::hcbp_op_t pop_op
);
  import hcbp_pkg::*;

  hcbp_op_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_op     = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/hcbp_back.sv]
// ----------------------------------------------------------------------------
// hcbp_back
// Appends code bits to the pending buffer; one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module hcbp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  hcbp_pkg::hcbp_op_t op,
  output logic               op_pop,
  hcbp_out_if.source         out_chan
);
  import hcbp_pkg::*;

  logic [PEND_W-1:0]  pend_r;
  logic [PCNT_W-1:0]  pcnt_r;
  logic               busy_r;
  logic [WORK_W-1:0]  work_r;
  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;

  logic [PEND_W-1:0]  pend_la;
  logic [CODE_W-1:0]  code_la;
  logic [WORK_W-1:0]  c_work;
  logic [TOTAL_W-1:0] c_total;
  logic [WORK_W-1:0]  sel_work;
  logic [TOTAL_W-1:0] sel_total;
  logic [WORK_W-1:0]  sh_work;
  logic [TOTAL_W-1:0] rem;
  logic               can_emit;
  logic               do_emit;
  logic               rem_short;
  logic [PEND_W-1:0]  pend_after_emit;
  logic [PEND_W-1:0]  pend_after_pop;

  // left-align pending bits and code bits, code right behind the pending ones
  assign pend_la = pend_r << (PCNT_W'(PEND_W) - pcnt_r);
  assign code_la = op.code << (LEN_W'(CODE_W) - op.len);

  always_comb begin
    c_work = {pend_la, {(WORK_W - PEND_W){1'b0}}};
    if (op.is_flush) begin
      c_total = (pcnt_r != '0) ? TOTAL_W'(BYTE_W) : '0;
    end else begin
      c_work  = c_work | ({code_la, {(WORK_W - CODE_W){1'b0}}} >> pcnt_r);
      c_total = TOTAL_W'(pcnt_r) + TOTAL_W'(op.len);
    end
  end

  assign sel_work  = busy_r ? work_r  : c_work;
  assign sel_total = busy_r ? total_r : c_total;
  assign sh_work   = sel_work << BYTE_W;
  assign rem       = sel_total - TOTAL_W'(BYTE_W);
  assign rem_short = (rem < TOTAL_W'(BYTE_W));

  assign can_emit = !out_valid_r || out_chan.ready;
  assign do_emit  = (busy_r || op_valid) && (sel_total >= TOTAL_W'(BYTE_W)) && can_emit;
  assign op_pop   = !busy_r && op_valid && ((c_total < TOTAL_W'(BYTE_W)) || can_emit);

  // leftover bits back to right-aligned form
  assign pend_after_emit = sh_work[WORK_W-1 -: PEND_W] >> (PCNT_W'(PEND_W) - rem[PCNT_W-1:0]);
  assign pend_after_pop  = c_work[WORK_W-1 -: PEND_W]
                           >> (PCNT_W'(PEND_W) - c_total[PCNT_W-1:0]);

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.last     = out_last_r;

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_byte_r <= sel_work[WORK_W-1 -: BYTE_W];
      out_last_r <= rem_short;
      work_r     <= sh_work;
      total_r    <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      pcnt_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_emit) begin
        out_valid_r <= 1'b1;
        if (rem_short) begin
          busy_r <= 1'b0;
          pend_r <= pend_after_emit;
          pcnt_r <= rem[PCNT_W-1:0];
        end else begin
          busy_r <= 1'b1;
        end
      end else begin
        if (out_chan.ready) begin
          out_valid_r <= 1'b0;
        end
        if (op_pop) begin
          pend_r <= pend_after_pop;
          pcnt_r <= c_total[PCNT_W-1:0];
        end
      end
    end
  end

endmodule

[rtl/core/huffman_code_bit_packer_top.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Table-driven Huffman encoder with byte packing of the code stream.
// ----------------------------------------------------------------------------
// The block takes one word per cycle. Load words write the code table, encode
// words look up a symbol and append its code, flush words pad the pending bits
// to a byte. The front stage reads the code table (one registered read) and
// places encode and flush work in a four-entry queue; the packer behind it
// drains the queue and drives an output register. Sustained rate is one word
// per cycle as long as words produce at most one byte each and the output is
// not stalled; a word that produces n bytes holds the packer until all n are
// out, one byte per cycle through the single output register, and the queue
// absorbs such bursts. Unloaded symbols have length zero from reset on; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  hcbp_in_if.sink     in_chan,
  hcbp_out_if.source  out_chan
);
  import hcbp_pkg::*;

  logic     q_push_valid;
  logic     q_push_ready;
  hcbp_op_t q_push_op;
  logic     q_pop_valid;
  logic     q_pop;
  hcbp_op_t q_pop_op;

  hcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_op    (q_push_op)
  );

  hcbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_op    (q_push_op),
    .pop_valid  (q_pop_valid),
    .pop        (q_pop),
    .pop_op     (q_pop_op)
  );

  hcbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (q_pop_valid),
    .op       (q_pop_op),
    .op_pop   (q_pop),
    .out_chan (out_chan)
  );

  // encode ops reaching the queue carry a real, saturated length
  a_push_len: assert property (@(posedge clk) disable iff (!rst_n)
    q_push_valid && q_push_ready && !q_push_op.is_flush
      |-> (q_push_op.len != '0) && (q_push_op.len <= LEN_W'(CAP_LEN)))
    else $error("encode op with bad length queued");

  // the packer never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_pop_valid)
    else $error("pop from empty queue");

  // flush ops carry no code length
  a_flush_len: assert property (@(posedge clk) disable iff (!rst_n)
    q_push_valid && q_push_op.is_flush |-> q_push_op.len == '0)
    else $error("flush op with nonzero length");

endmodule

[tb/hcbp_packer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hcbp_packer_checker
// Watches both channels of the bit packer, predicts the packed byte stream
// from the accepted words and compares every byte that leaves the block.
// ----------------------------------------------------------------------------
module hcbp_packer_checker #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [hcbp_pkg::MODE_W-1:0] in_mode,
  input  logic [hcbp_pkg::SYM_W-1:0]  in_symbol,
  input  logic [hcbp_pkg::CODE_W-1:0] in_code_word,
  input  logic [hcbp_pkg::LEN_W-1:0]  in_code_length,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [hcbp_pkg::BYTE_W-1:0] out_byte,
  input  logic                        out_last,
  output int                          fail_count,
  output int                          open_count,
  output int                          words_seen,
  output int                          bytes_seen
);
  import hcbp_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  packed_byte_t      byte_fifo [$];
  logic [CODE_W-1:0] code_tbl [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_tbl  [SYMBOL_COUNT];
  logic [PEND_W-1:0] held_bits;
  logic [PCNT_W-1:0] held_count;
  int                fails;
  int                words;
  int                bytes;

  task automatic report_mismatch(input string msg);
    fails++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Update the table or the pending bits and queue the bytes this word makes.
  task automatic pack_word(input logic [MODE_W-1:0] mode_bits,
                           input logic [SYM_W-1:0]  sym,
                           input logic [CODE_W-1:0] word,
                           input logic [LEN_W-1:0]  len);
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] made [4];
    int                clen;
    int                cnt;
    int                n;
    int                b;
    case (mode_t'(mode_bits))
      MODE_LOAD: begin
        if (sym < SYMBOL_COUNT) begin
          clen = (len > CAP_LEN) ? CAP_LEN : int'(len);
          code = word;
          // keep only the low clen bits
          if (clen < CODE_W) code = word & ~({CODE_W{1'b1}} << clen);
          code_tbl[sym] = code;
          len_tbl[sym]  = LEN_W'(clen);
        end
      end
      MODE_ENCODE: begin
        if (sym < SYMBOL_COUNT) begin
          code = code_tbl[sym];
          clen = int'(len_tbl[sym]);
          acc  = {1'b0, held_bits};
          cnt  = int'(held_count);
          n    = 0;
          for (b = clen - 1; b >= 0; b--) begin
            acc = {acc[BYTE_W-2:0], code[b]};
            cnt++;
            if (cnt == BYTE_W) begin
              made[n] = acc;
              n++;
              acc = '0;
              cnt = 0;
            end
          end
          held_bits  = acc[PEND_W-1:0];
          held_count = PCNT_W'(cnt);
          for (b = 0; b < n; b++) begin
            byte_fifo.push_back('{data: made[b], last: (b == n - 1)});
          end
        end
      end
      MODE_FLUSH: begin
        if (held_count != 0) begin
          // pad with zeros on the right
          acc = {1'b0, held_bits};
          acc = acc << (BYTE_W - int'(held_count));
          byte_fifo.push_back('{data: acc, last: 1'b1});
          held_bits  = '0;
          held_count = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst_n) begin
      for (int e = 0; e < SYMBOL_COUNT; e++) begin
        code_tbl[e] = '0;
        len_tbl[e]  = '0;
      end
      held_bits  = '0;
      held_count = '0;
      byte_fifo.delete();
    end else begin
      if (in_valid && in_ready) begin
        words++;
        pack_word(in_mode, in_symbol, in_code_word, in_code_length);
      end
      if (out_valid && out_ready) begin
        bytes++;
        if (byte_fifo.size() == 0) begin
          report_mismatch($sformatf("byte 0x%02h last %0b with nothing expected",
                                    out_byte, out_last));
        end else begin
          want = byte_fifo.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("byte got 0x%02h expected 0x%02h",
                                      out_byte, want.data));
          if (out_last !== want.last)
            report_mismatch($sformatf("last got %0b expected %0b on byte 0x%02h",
                                      out_last, want.last, want.data));
        end
      end
    end
    fail_count <= fails;
    open_count <= byte_fifo.size();
    words_seen <= words;
    bytes_seen <= bytes;
  end

endmodule

[tb/tb_huffman_code_bit_packer_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_code_bit_packer_top
// Drives load, encode, flush and reserved-mode words into the bit packer with
// random gaps and output stalls; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer_top;
  import hcbp_pkg::*;

  localparam int SYMBOLS     = 256;
  localparam int STALL_PCT   = 20;
  localparam int QUIET_LIMIT = 2000;
  localparam int WORD_GOAL   = 350;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             stall_en;
  int               fail_count;
  int               open_count;
  int               words_seen;
  int               bytes_seen;
  int               quiet_cycles;
  logic [SYM_W-1:0] sym_pool [$];

  hcbp_in_if  in_if ();
  hcbp_out_if out_if ();

  huffman_code_bit_packer_top #(
    .SYMBOL_COUNT(SYMBOLS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  hcbp_packer_checker #(
    .SYMBOL_COUNT(SYMBOLS)
  ) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_mode        (in_if.mode),
    .in_symbol      (in_if.symbol),
    .in_code_word   (in_if.code_word),
    .in_code_length (in_if.code_length),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_byte       (out_if.out_byte),
    .out_last       (out_if.last),
    .fail_count     (fail_count),
    .open_count     (open_count),
    .words_seen     (words_seen),
    .bytes_seen     (bytes_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_en) begin
      out_if.ready <= ($urandom_range(99) >= STALL_PCT);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // End the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input mode_t            mode,
                           input logic [SYM_W-1:0]  sym,
                           input logic [CODE_W-1:0] word,
                           input logic [LEN_W-1:0]  len);
    if (stall_en && $urandom_range(99) < STALL_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= mode;
    in_if.symbol      <= sym;
    in_if.code_word   <= word;
    in_if.code_length <= len;
    do @(posedge clk); while (!in_if.ready);
  endtask

  initial begin : stimulus
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    int               pick;
    int               counted;
    rst_n             <= 1'b0;
    stall_en          <= 1'b1;
    in_if.valid       <= 1'b0;
    in_if.mode        <= MODE_LOAD;
    in_if.symbol      <= '0;
    in_if.code_word   <= '0;
    in_if.code_length <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty flush, unloaded symbol, reserved mode, edge lengths
    send_word(MODE_FLUSH,  8'h00, '0, '0);
    send_word(MODE_ENCODE, 8'h00, '0, '0);
    send_word(MODE_RSVD,   8'hFF, '1, '1);
    send_word(MODE_LOAD,   8'h00, '1, 6'd1);
    send_word(MODE_LOAD,   8'hFF, '1, 6'd32);
    send_word(MODE_LOAD,   8'h80, '0, 6'd63);
    send_word(MODE_LOAD,   8'h01, 32'hA5A5_A5A5, 6'd5);
    send_word(MODE_LOAD,   8'h02, 32'h0000_FFFF, 6'd0);
    send_word(MODE_LOAD,   8'h03, 32'hFFFF_FF7F, 6'd7);
    send_word(MODE_ENCODE, 8'h00, '0, '0);
    send_word(MODE_ENCODE, 8'hFF, '0, '0);
    send_word(MODE_ENCODE, 8'h80, '0, '0);
    send_word(MODE_ENCODE, 8'h02, '0, '0);
    send_word(MODE_ENCODE, 8'h01, '0, '0);
    send_word(MODE_FLUSH,  8'h00, '0, '0);
    send_word(MODE_FLUSH,  8'hFF, '1, '1);
    send_word(MODE_ENCODE, 8'h03, '0, '0);
    send_word(MODE_FLUSH,  8'h00, '0, '0);
    send_word(MODE_ENCODE, 8'hFF, '1, '1);
    send_word(MODE_FLUSH,  8'h00, '0, '0);
    send_word(MODE_LOAD,   8'hFF, 32'h1234_5678, 6'd40);
    send_word(MODE_ENCODE, 8'hFF, '0, '0);
    send_word(MODE_ENCODE, 8'h55, '0, '0);
    sym_pool = '{8'h00, 8'h01, 8'h03, 8'h80, 8'hFF};

    // build a working table with short codes
    counted = 0;
    repeat (24) begin
      sym = SYM_W'($urandom_range(255));
      send_word(MODE_LOAD, sym, $urandom, LEN_W'($urandom_range(1, 12)));
      sym_pool.push_back(sym);
      counted++;
    end

    while (counted < WORD_GOAL) begin
      // middle stretch runs with no gaps and no stalls
      stall_en <= !(counted >= 130 && counted < 230);
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_word(MODE_RSVD, SYM_W'($urandom_range(255)), $urandom,
                  LEN_W'($urandom_range(63)));
      end else if (pick < 10) begin
        sym = SYM_W'($urandom_range(255));
        len = $urandom_range(1) ? LEN_W'($urandom_range(1, 12))
                                : LEN_W'($urandom_range(63));
        send_word(MODE_LOAD, sym, $urandom, len);
        if (len != 0) sym_pool.push_back(sym);
        counted++;
      end else if (pick < 16) begin
        send_word(MODE_FLUSH, SYM_W'($urandom_range(255)), $urandom,
                  LEN_W'($urandom_range(63)));
        counted++;
      end else begin
        if ($urandom_range(99) < 85) begin
          sym = sym_pool[$urandom_range(sym_pool.size() - 1)];
        end else begin
          sym = SYM_W'($urandom_range(255));
        end
        send_word(MODE_ENCODE, sym, $urandom, LEN_W'($urandom_range(63)));
        counted++;
      end
    end
    in_if.valid <= 1'b0;

    // let the last accepted word reach the checker, then drain
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run moved %0d words into the packer and compared %0d packed bytes.",
             words_seen, bytes_seen);
    $display("Covered empty, zero-length and saturated codes, flushes and a stall-free burst.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
